// File: sv/record_exchange_sorter_defines.svh
// Assertion macros used by the checker file of the record exchange sorter.
// All of them sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef RECORD_EXCHANGE_SORTER_DEFINES_SVH
`define RECORD_EXCHANGE_SORTER_DEFINES_SVH

// Property checked every cycle outside reset.
`define RES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, with the antecedent and the consequent given apart.
`define RES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define RES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/res_pkg.sv
package res_pkg;

    // Capacity of one set and derived widths.
    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 24;
    localparam int WORD_W = 32;

    // Read address selection codes.
    localparam logic [1:0] RD_I  = 2'd0;
    localparam logic [1:0] RD_J  = 2'd1;
    localparam logic [1:0] RD_J1 = 2'd2;

    typedef struct packed {
        logic        [KEY_W-1:0]  energy_key;
        logic signed [WORD_W-1:0] pt_mean_in;
        logic signed [WORD_W-1:0] pt_spread_in;
        logic signed [WORD_W-1:0] cal_mean_in;
        logic signed [WORD_W-1:0] cal_spread_in;
        logic                     last_in;
    } in_item_t;

    typedef struct packed {
        logic        [KEY_W-1:0]  energy_out;
        logic signed [WORD_W-1:0] pt_mean_out;
        logic signed [WORD_W-1:0] pt_spread_out;
        logic signed [WORD_W-1:0] cal_mean_out;
        logic signed [WORD_W-1:0] cal_spread_out;
        logic                     last_out;
        logic                     overflowed;
    } out_item_t;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] pt_mean;
        logic [WORD_W-1:0] pt_spread;
        logic [WORD_W-1:0] cal_mean;
        logic [WORD_W-1:0] cal_spread;
    } record_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store;
        logic       sort_init;
        logic [1:0] rd_sel;
        logic       set_j;
        logic       cur_load;
        logic       cmp_step;
        logic       emit;
        logic       next_i;
        logic       finish;
    } res_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic i_last;
        logic j_last;
        logic out_free;
    } res_stat_t;

endpackage

// File: sv/record_exchange_sorter.sv
// Record exchange sorter.
// Records enter on the rec channel (rec_valid, rec_stall, rec_data), one transfer per
// cycle while the block is loading. A record with last_in set closes the set; rec_stall
// then stays high until the final result of the set has entered the output register.
// Up to DEPTH records are kept per set; later ones are dropped and every result of that
// set carries overflowed. The set is sorted ascending by energy key with an in-place
// exchange sort over a record memory with one read and one write port, holding the
// record for position i in a register. Each position i is read from memory, loaded as
// the held record, compared in turn against each later record, and then emitted; the
// sort runs one compare per cycle through the memory read port.
// Results leave through an output register; a stall on sorted_stall holds that register
// and pauses the sort at its next emit. The final result of a set has last_out set, and
// loading resumes in the cycle after it enters the output register.
// Reset clears the record count, the overflow flag and the state machine; the memory
// content is not cleared, since only entries written in the current set are read.
module record_exchange_sorter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    output logic               rec_stall,
    input  res_pkg::in_item_t  rec_data,
    output logic               sorted_valid,
    input  logic               sorted_stall,
    output res_pkg::out_item_t sorted_data
);

    res_pkg::res_cmd_t  cmd;
    res_pkg::res_stat_t stat;

    res_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_last  (rec_data.last_in),
        .rec_stall (rec_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    res_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_data     (rec_data),
        .cmd          (cmd),
        .stat         (stat),
        .sorted_valid (sorted_valid),
        .sorted_stall (sorted_stall),
        .sorted_data  (sorted_data)
    );

endmodule

// File: sv/res_ctrl.sv
module res_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  logic               rec_last,
    output logic               rec_stall,
    input  res_pkg::res_stat_t stat,
    output res_pkg::res_cmd_t  cmd
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_READ_I = 3'd1;
    localparam logic [2:0] S_CUR    = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = res_pkg::RD_I;
        rec_stall  = 1'b1;
        case (state_reg)
            S_LOAD:
            begin
                rec_stall = 1'b0;
                cmd.store = rec_valid;
                if (rec_valid && rec_last)
                begin
                    cmd.sort_init = 1'b1;
                    state_next    = S_READ_I;
                end
            end
            S_READ_I:
            begin
                cmd.rd_sel = res_pkg::RD_I;
                cmd.set_j  = 1'b1;
                state_next = S_CUR;
            end
            S_CUR:
            begin
                cmd.cur_load = 1'b1;
                if (stat.i_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_sel = res_pkg::RD_J;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                cmd.rd_sel   = res_pkg::RD_J1;
                if (stat.j_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.i_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.next_i = 1'b1;
                        state_next = S_READ_I;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// File: sv/res_datapath.sv
module res_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  res_pkg::in_item_t  rec_data,
    input  res_pkg::res_cmd_t  cmd,
    output res_pkg::res_stat_t stat,
    output logic               sorted_valid,
    input  logic               sorted_stall,
    output res_pkg::out_item_t sorted_data
);

    res_pkg::record_t mem [res_pkg::DEPTH];

    logic [res_pkg::CNT_W-1:0] count_reg;
    logic [res_pkg::CNT_W-1:0] count_next;
    logic                      drop_reg;
    logic                      drop_next;
    logic [res_pkg::IDX_W-1:0] i_reg;
    logic [res_pkg::IDX_W-1:0] i_next;
    logic [res_pkg::IDX_W-1:0] j_reg;
    logic [res_pkg::IDX_W-1:0] j_next;
    res_pkg::record_t          cur_reg;
    res_pkg::record_t          cur_next;
    res_pkg::record_t          rd_data_reg;
    res_pkg::out_item_t        out_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic [res_pkg::CNT_W-1:0] last_idx;
    logic                      full;
    logic                      swap;
    logic [res_pkg::IDX_W-1:0] rd_addr;
    logic                      wr_en;
    logic [res_pkg::IDX_W-1:0] wr_addr;
    res_pkg::record_t          wr_data;
    res_pkg::record_t          in_rec;

    // Status toward the controller.
    assign last_idx      = count_reg - res_pkg::CNT_W'(1);
    assign full          = (count_reg == res_pkg::CNT_W'(res_pkg::DEPTH));
    assign stat.i_last   = (res_pkg::CNT_W'(i_reg) == last_idx);
    assign stat.j_last   = (res_pkg::CNT_W'(j_reg) == last_idx);
    assign stat.out_free = !out_valid_reg || !sorted_stall;

    // The held record moves out to position j when its key is larger.
    assign swap = (cur_reg.key > rd_data_reg.key);

    assign in_rec = '{key:        rec_data.energy_key,
                      pt_mean:    rec_data.pt_mean_in,
                      pt_spread:  rec_data.pt_spread_in,
                      cal_mean:   rec_data.cal_mean_in,
                      cal_spread: rec_data.cal_spread_in};

    // Read address selection.
    always_comb
    begin
        case (cmd.rd_sel)
            res_pkg::RD_I:  rd_addr = i_reg;
            res_pkg::RD_J:  rd_addr = j_reg;
            res_pkg::RD_J1: rd_addr = j_reg + res_pkg::IDX_W'(1);
            default:        rd_addr = i_reg;
        endcase
    end

    // Single write port: loading takes it, or a swap during the sort.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = cur_reg;
        if (cmd.store && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[res_pkg::IDX_W-1:0];
            wr_data = in_rec;
        end
        else if (cmd.cmp_step && swap)
        begin
            wr_en = 1'b1;
        end
    end

    // Record memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Next values of counters, flags and the held record.
    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        if (cmd.store)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + res_pkg::CNT_W'(1);
            end
        end
        if (cmd.sort_init)
        begin
            i_next = '0;
        end
        if (cmd.next_i)
        begin
            i_next = i_reg + res_pkg::IDX_W'(1);
        end
        if (cmd.set_j)
        begin
            j_next = i_reg + res_pkg::IDX_W'(1);
        end
        if (cmd.cur_load)
        begin
            cur_next = rd_data_reg;
        end
        if (cmd.cmp_step)
        begin
            j_next = j_reg + res_pkg::IDX_W'(1);
            if (swap)
            begin
                cur_next = rd_data_reg;
            end
        end
        if (cmd.finish)
        begin
            count_next = '0;
            drop_next  = 1'b0;
        end
    end

    // Output register valid.
    assign out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && sorted_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.emit)
        begin
            out_reg.energy_out     <= cur_reg.key;
            out_reg.pt_mean_out    <= cur_reg.pt_mean;
            out_reg.pt_spread_out  <= cur_reg.pt_spread;
            out_reg.cal_mean_out   <= cur_reg.cal_mean;
            out_reg.cal_spread_out <= cur_reg.cal_spread;
            out_reg.last_out       <= stat.i_last;
            out_reg.overflowed     <= drop_reg;
        end
    end

    assign sorted_valid = out_valid_reg;
    assign sorted_data  = out_reg;

endmodule

// File: sv/res_checker.sv
`include "record_exchange_sorter_defines.svh"

module res_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rec_valid,
    input logic               rec_stall,
    input res_pkg::in_item_t  rec_data,
    input logic               sorted_valid,
    input logic               sorted_stall,
    input res_pkg::out_item_t sorted_data
);

    // A stalled result stays offered and unchanged.
    `RES_ASSERT_NEXT(a_out_hold, sorted_valid && sorted_stall, sorted_valid, "result dropped while stalled")
    `RES_ASSERT_NEXT(a_out_stable, sorted_valid && sorted_stall, $stable(sorted_data), "stalled result changed")

    // The transfer that closes a set raises rec_stall right after it.
    `RES_ASSERT_NEXT(a_last_stalls, rec_valid && !rec_stall && rec_data.last_in, rec_stall, "input taken after last record")

    // A result other than the final one is only shown while the input is held off.
    `RES_ASSERT_IMP(a_mid_set_stall, sorted_valid && !sorted_data.last_out, rec_stall, "input open inside a set")

endmodule

bind record_exchange_sorter res_checker u_res_checker (.*);
